@@ design/idll_pkg.sv @@
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and defaults for the indexed doubly linked list block.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int POOL_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int OP_W           = 3;
  localparam int ST_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK    = 3'd0,
    OP_PUSH_FRONT   = 3'd1,
    OP_POP_BACK     = 3'd2,
    OP_POP_FRONT    = 3'd3,
    OP_INSERT_AFTER = 3'd4,
    OP_ERASE        = 3'd5,
    OP_READ         = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // write strobes for the three entry memories
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic value_we;
  } wr_en_t;

endpackage

@@ design/indexed_doubly_linked_list.sv @@
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// A doubly linked list over a fixed pool of entries with a free chain; entry
// 0 is the sentinel. Each item runs one operation (push back or front, pop
// back or front, insert after, erase, read) and gives one result with value,
// links, head, tail, count and status. Each item passes through the states
// S_IDLE, S_EXEC, S_WRITE2 and S_OUT: the accept in S_IDLE reads the links of
// the target entry and the free-chain top, S_EXEC makes the first round of
// link writes and updates head, tail, free top and count, S_WRITE2 makes the
// remaining neighbor link writes, and S_OUT moves the result into the output
// register. The two write states come from the single write port of each link
// memory. The output register holds a result until its transfer, and the next
// item may already be taken in while it waits; a result that is still not
// taken when the next one is ready holds the block in S_OUT.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list #(
  parameter int POOL_DEPTH = idll_pkg::POOL_DEPTH_DEF,
  parameter int VALUE_BITS = idll_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [idll_pkg::OP_W-1:0]     in_operation,
  input  logic [$clog2(POOL_DEPTH)-1:0] in_position,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VALUE_BITS-1:0]         out_result_value,
  output logic [$clog2(POOL_DEPTH)-1:0] out_entry_next,
  output logic [$clog2(POOL_DEPTH)-1:0] out_entry_prev,
  output logic [$clog2(POOL_DEPTH)-1:0] out_new_entry,
  output logic [$clog2(POOL_DEPTH)-1:0] out_head_index,
  output logic [$clog2(POOL_DEPTH)-1:0] out_tail_index,
  output logic [$clog2(POOL_DEPTH)-1:0] out_count,
  output logic [idll_pkg::ST_W-1:0]     out_status
);
  import idll_pkg::*;

  localparam int             IDX_W   = $clog2(POOL_DEPTH);
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W+1)'(POOL_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WRITE2,
    S_OUT
  } state_t;

  state_t                state_r;
  op_t                   op_r;
  logic [IDX_W-1:0]      pos_r;
  logic [VALUE_BITS-1:0] val_r;

  logic [IDX_W-1:0]      first_r;
  logic [IDX_W-1:0]      last_r;
  logic [IDX_W-1:0]      free_r;
  logic [IDX_W-1:0]      count_r;
  logic [POOL_DEPTH-1:0] in_use_r;

  wr_en_t                wr2_en_r;
  logic [IDX_W-1:0]      wr2_next_addr_r;
  logic [IDX_W-1:0]      wr2_next_data_r;
  logic [IDX_W-1:0]      wr2_prev_addr_r;
  logic [IDX_W-1:0]      wr2_prev_data_r;

  logic [VALUE_BITS-1:0] res_value_r;
  logic [IDX_W-1:0]      res_next_r;
  logic [IDX_W-1:0]      res_prev_r;
  logic [IDX_W-1:0]      res_new_r;
  status_t               res_status_r;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [IDX_W-1:0]      out_next_r;
  logic [IDX_W-1:0]      out_prev_r;
  logic [IDX_W-1:0]      out_new_r;
  logic [IDX_W-1:0]      out_head_r;
  logic [IDX_W-1:0]      out_tail_r;
  logic [IDX_W-1:0]      out_count_r;
  status_t               out_status_r;

  // result moves into the output register this cycle
  logic                  res_load;

  // store interface
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr_a;
  logic [IDX_W-1:0]      rd_next_a;
  logic [IDX_W-1:0]      rd_next_b;
  logic [IDX_W-1:0]      rd_prev;
  logic [VALUE_BITS-1:0] rd_value;
  wr_en_t                wr_en;
  logic [IDX_W-1:0]      wr_next_addr;
  logic [IDX_W-1:0]      wr_next_data;
  logic [IDX_W-1:0]      wr_prev_addr;
  logic [IDX_W-1:0]      wr_prev_data;

  // operation decode, valid in S_EXEC
  status_t               status;
  logic [VALUE_BITS-1:0] res_value;
  logic [IDX_W-1:0]      res_next;
  logic [IDX_W-1:0]      res_prev;
  logic [IDX_W-1:0]      res_new;
  logic [IDX_W-1:0]      first_nxt;
  logic [IDX_W-1:0]      last_nxt;
  logic [IDX_W-1:0]      free_nxt;
  logic [IDX_W-1:0]      count_nxt;
  logic                  set_use;
  logic                  clr_use;
  logic [IDX_W-1:0]      use_idx;
  logic                  pos_ok;
  logic                  push_b;
  logic                  push_f;
  logic                  ins;
  logic                  unlink;
  logic                  alloc;
  logic [IDX_W-1:0]      unlink_e;
  wr_en_t                wr1_en;
  logic [IDX_W-1:0]      wr1_next_addr;
  logic [IDX_W-1:0]      wr1_next_data;
  logic [IDX_W-1:0]      wr1_prev_addr;
  logic [IDX_W-1:0]      wr1_prev_data;
  wr_en_t                wr2_en;
  logic [IDX_W-1:0]      wr2_next_addr;
  logic [IDX_W-1:0]      wr2_next_data;
  logic [IDX_W-1:0]      wr2_prev_addr;
  logic [IDX_W-1:0]      wr2_prev_data;

  assign in_stall = (state_r != S_IDLE);
  assign rd_en    = in_valid && !in_stall;
  assign res_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // port a reads the entry the operation works on
  always_comb begin
    case (op_t'(in_operation))
      OP_POP_BACK:   rd_addr_a = last_r;
      OP_POP_FRONT:  rd_addr_a = first_r;
      OP_PUSH_BACK,
      OP_PUSH_FRONT: rd_addr_a = free_r;
      default:       rd_addr_a = in_position;
    endcase
  end

  idll_store #(
    .POOL_DEPTH (POOL_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_en         (rd_en),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (free_r),
    .rd_next_a     (rd_next_a),
    .rd_next_b     (rd_next_b),
    .rd_prev       (rd_prev),
    .rd_value      (rd_value),
    .wr_en         (wr_en),
    .wr_next_addr  (wr_next_addr),
    .wr_next_data  (wr_next_data),
    .wr_prev_addr  (wr_prev_addr),
    .wr_prev_data  (wr_prev_data),
    .wr_value_addr (free_r),
    .wr_value_data (val_r)
  );

  always_comb begin
    status        = ST_OK;
    res_value     = '0;
    res_next      = '0;
    res_prev      = '0;
    res_new       = '0;
    first_nxt     = first_r;
    last_nxt      = last_r;
    free_nxt      = free_r;
    count_nxt     = count_r;
    set_use       = 1'b0;
    clr_use       = 1'b0;
    use_idx       = '0;
    push_b        = 1'b0;
    push_f        = 1'b0;
    ins           = 1'b0;
    unlink        = 1'b0;
    unlink_e      = '0;
    wr1_en        = '0;
    wr1_next_addr = '0;
    wr1_next_data = '0;
    wr1_prev_addr = '0;
    wr1_prev_data = '0;
    wr2_en        = '0;
    wr2_next_addr = '0;
    wr2_next_data = '0;
    wr2_prev_addr = '0;
    wr2_prev_data = '0;

    pos_ok = ({1'b0, pos_r} < DEPTH_X) && (pos_r != '0) && in_use_r[pos_r];

    case (op_r)
      OP_PUSH_BACK: begin
        if (free_r == '0) status = ST_FULL;
        else push_b = 1'b1;
      end
      OP_PUSH_FRONT: begin
        if (free_r == '0) status = ST_FULL;
        else push_f = 1'b1;
      end
      OP_POP_BACK: begin
        if (count_r == '0 || first_r == '0) begin
          status = ST_EMPTY;
        end else begin
          unlink   = 1'b1;
          unlink_e = last_r;
        end
      end
      OP_POP_FRONT: begin
        if (count_r == '0 || first_r == '0) begin
          status = ST_EMPTY;
        end else begin
          unlink   = 1'b1;
          unlink_e = first_r;
        end
      end
      OP_INSERT_AFTER: begin
        if (!pos_ok) status = ST_BADPOS;
        else if (free_r == '0) status = ST_FULL;
        else if (pos_r == last_r) push_b = 1'b1;
        else ins = 1'b1;
      end
      OP_ERASE: begin
        if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          unlink   = 1'b1;
          unlink_e = pos_r;
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status = ST_BADPOS;
        end else begin
          res_value = rd_value;
          res_next  = rd_next_a;
          res_prev  = rd_prev;
        end
      end
      default: ;
    endcase

    // new entry comes off the top of the free chain
    alloc = push_b || push_f || ins;
    if (alloc) begin
      res_new         = free_r;
      free_nxt        = rd_next_b;
      count_nxt       = count_r + 1'b1;
      set_use         = 1'b1;
      use_idx         = free_r;
      wr1_en.value_we = 1'b1;
      wr1_en.next_we  = 1'b1;
      wr1_en.prev_we  = 1'b1;
      wr1_next_addr   = free_r;
      wr1_prev_addr   = free_r;
    end

    if (push_b) begin
      wr1_next_data = '0;
      wr1_prev_data = last_r;
      if (last_r == '0) begin
        first_nxt = free_r;
      end else begin
        wr2_en.next_we = 1'b1;
        wr2_next_addr  = last_r;
        wr2_next_data  = free_r;
      end
      last_nxt = free_r;
    end

    if (push_f) begin
      wr1_next_data = first_r;
      wr1_prev_data = '0;
      if (first_r == '0) begin
        last_nxt = free_r;
      end else begin
        wr2_en.prev_we = 1'b1;
        wr2_prev_addr  = first_r;
        wr2_prev_data  = free_r;
      end
      first_nxt = free_r;
    end

    if (ins) begin
      wr1_next_data  = rd_next_a;
      wr1_prev_data  = pos_r;
      wr2_en.next_we = 1'b1;
      wr2_next_addr  = pos_r;
      wr2_next_data  = free_r;
      wr2_en.prev_we = 1'b1;
      wr2_prev_addr  = rd_next_a;
      wr2_prev_data  = free_r;
    end

    // unlinked entry goes back on top of the free chain
    if (unlink) begin
      res_value      = rd_value;
      wr1_en.next_we = 1'b1;
      wr1_en.prev_we = 1'b1;
      wr1_next_addr  = unlink_e;
      wr1_next_data  = free_r;
      wr1_prev_addr  = unlink_e;
      wr1_prev_data  = '0;
      clr_use        = 1'b1;
      use_idx        = unlink_e;
      free_nxt       = unlink_e;
      count_nxt      = count_r - 1'b1;
      if (rd_prev == '0) begin
        first_nxt = rd_next_a;
      end else begin
        wr2_en.next_we = 1'b1;
        wr2_next_addr  = rd_prev;
        wr2_next_data  = rd_next_a;
      end
      if (rd_next_a == '0) begin
        last_nxt = rd_prev;
      end else begin
        wr2_en.prev_we = 1'b1;
        wr2_prev_addr  = rd_next_a;
        wr2_prev_data  = rd_prev;
      end
    end
  end

  always_comb begin
    wr_en        = '0;
    wr_next_addr = wr1_next_addr;
    wr_next_data = wr1_next_data;
    wr_prev_addr = wr1_prev_addr;
    wr_prev_data = wr1_prev_data;
    case (state_r)
      S_EXEC: begin
        wr_en = wr1_en;
      end
      S_WRITE2: begin
        wr_en        = wr2_en_r;
        wr_next_addr = wr2_next_addr_r;
        wr_next_data = wr2_next_data_r;
        wr_prev_addr = wr2_prev_addr_r;
        wr_prev_data = wr2_prev_data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= '0;
      last_r      <= '0;
      free_r      <= IDX_W'(1);
      count_r     <= '0;
      in_use_r    <= '0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op_t'(in_operation);
            pos_r   <= in_position;
            val_r   <= in_value;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          first_r <= first_nxt;
          last_r  <= last_nxt;
          free_r  <= free_nxt;
          count_r <= count_nxt;
          if (set_use) begin
            in_use_r[use_idx] <= 1'b1;
          end
          if (clr_use) begin
            in_use_r[use_idx] <= 1'b0;
          end
          wr2_en_r        <= wr2_en;
          wr2_next_addr_r <= wr2_next_addr;
          wr2_next_data_r <= wr2_next_data;
          wr2_prev_addr_r <= wr2_prev_addr;
          wr2_prev_data_r <= wr2_prev_data;
          res_value_r     <= res_value;
          res_next_r      <= res_next;
          res_prev_r      <= res_prev;
          res_new_r       <= res_new;
          res_status_r    <= status;
          state_r         <= S_WRITE2;
        end
        S_WRITE2: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (res_load) begin
            out_value_r  <= res_value_r;
            out_next_r   <= res_next_r;
            out_prev_r   <= res_prev_r;
            out_new_r    <= res_new_r;
            out_head_r   <= first_r;
            out_tail_r   <= last_r;
            out_count_r  <= count_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_entry_next   = out_next_r;
  assign out_entry_prev   = out_prev_r;
  assign out_new_entry    = out_new_r;
  assign out_head_index   = out_head_r;
  assign out_tail_index   = out_tail_r;
  assign out_count        = out_count_r;
  assign out_status       = out_status_r;

`ifndef NO_ASSERTIONS
  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '0) == (first_r == '0)) && ((count_r == '0) == (last_r == '0)))
    else $error("head or tail disagrees with entry count");

  a_full_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r == '0) |-> ({1'b0, count_r} == DEPTH_X - 1'b1))
    else $error("free chain exhausted with entries unaccounted for");

  a_free_top_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r != '0) |-> !in_use_r[free_r])
    else $error("free chain top is a listed entry");
`endif

endmodule

@@ design/idll_store.sv @@
// ----------------------------------------------------------------------------
// idll_store
// Entry memories: next links, previous links and stored values. Reads are
// registered. Next links of entries never handed out read as the initial
// free chain, tracked by a fill count.
// ----------------------------------------------------------------------------
module idll_store #(
  parameter int POOL_DEPTH = idll_pkg::POOL_DEPTH_DEF,
  parameter int VALUE_BITS = idll_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(POOL_DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(POOL_DEPTH)-1:0] rd_addr_b,
  output logic [$clog2(POOL_DEPTH)-1:0] rd_next_a,
  output logic [$clog2(POOL_DEPTH)-1:0] rd_next_b,
  output logic [$clog2(POOL_DEPTH)-1:0] rd_prev,
  output logic [VALUE_BITS-1:0]         rd_value,
  input  idll_pkg::wr_en_t              wr_en,
  input  logic [$clog2(POOL_DEPTH)-1:0] wr_next_addr,
  input  logic [$clog2(POOL_DEPTH)-1:0] wr_next_data,
  input  logic [$clog2(POOL_DEPTH)-1:0] wr_prev_addr,
  input  logic [$clog2(POOL_DEPTH)-1:0] wr_prev_data,
  input  logic [$clog2(POOL_DEPTH)-1:0] wr_value_addr,
  input  logic [VALUE_BITS-1:0]         wr_value_data
);
  import idll_pkg::*;

  localparam int              IDX_W   = $clog2(POOL_DEPTH);
  localparam logic [IDX_W:0]  DEPTH_X = (IDX_W+1)'(POOL_DEPTH);

  logic [IDX_W-1:0]      next_mem  [POOL_DEPTH];
  logic [IDX_W-1:0]      prev_mem  [POOL_DEPTH];
  logic [VALUE_BITS-1:0] value_mem [POOL_DEPTH];

  // entries at or above this index have never had a next link written
  logic [IDX_W:0]        fill_r;

  logic [IDX_W-1:0]      next_a_raw_r;
  logic [IDX_W-1:0]      next_b_raw_r;
  logic [IDX_W-1:0]      addr_a_r;
  logic [IDX_W-1:0]      addr_b_r;
  logic                  fresh_a_r;
  logic                  fresh_b_r;
  logic [IDX_W-1:0]      prev_r;
  logic [VALUE_BITS-1:0] value_r;

  function automatic logic [IDX_W-1:0] chain_next(input logic [IDX_W-1:0] a);
    logic [IDX_W:0] s;
    s = {1'b0, a} + 1'b1;
    return (s == DEPTH_X) ? '0 : s[IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en.next_we) begin
      next_mem[wr_next_addr] <= wr_next_data;
    end
    if (wr_en.prev_we) begin
      prev_mem[wr_prev_addr] <= wr_prev_data;
    end
    if (wr_en.value_we) begin
      value_mem[wr_value_addr] <= wr_value_data;
    end
    if (rd_en) begin
      next_a_raw_r <= next_mem[rd_addr_a];
      next_b_raw_r <= next_mem[rd_addr_b];
      prev_r       <= prev_mem[rd_addr_a];
      value_r      <= value_mem[rd_addr_a];
      addr_a_r     <= rd_addr_a;
      addr_b_r     <= rd_addr_b;
      fresh_a_r    <= ({1'b0, rd_addr_a} >= fill_r);
      fresh_b_r    <= ({1'b0, rd_addr_b} >= fill_r);
    end
  end

  // fresh entries leave the free chain in index order, so one count covers them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= (IDX_W+1)'(1);
    end else if (wr_en.next_we && ({1'b0, wr_next_addr} == fill_r)) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  assign rd_next_a = fresh_a_r ? chain_next(addr_a_r) : next_a_raw_r;
  assign rd_next_b = fresh_b_r ? chain_next(addr_b_r) : next_b_raw_r;
  assign rd_prev   = prev_r;
  assign rd_value  = value_r;

endmodule

@@ sim/indexed_doubly_linked_list_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_test
// Drives list operations into the linked list block with random idle and
// stall cycles. A local copy of the pool, links and free chain predicts every
// result, and the monitor compares each returned field in order.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_test;
  import idll_pkg::*;

  localparam int IDX_W        = $clog2(POOL_DEPTH_DEF);
  localparam int VAL_W        = VALUE_BITS_DEF;
  localparam int SLOTS        = POOL_DEPTH_DEF;
  localparam int RANDOM_OPS   = 1630;
  localparam int PHASE_LEN    = 150;
  localparam int IDLE_PCT     = 37;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 900;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
    logic [IDX_W-1:0] new_entry;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] count;
    status_t          status;
  } list_resp_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0]  in_operation = '0;
  logic [IDX_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VAL_W-1:0] out_result_value;
  logic [IDX_W-1:0] out_entry_next;
  logic [IDX_W-1:0] out_entry_prev;
  logic [IDX_W-1:0] out_new_entry;
  logic [IDX_W-1:0] out_head_index;
  logic [IDX_W-1:0] out_tail_index;
  logic [IDX_W-1:0] out_count;
  logic [ST_W-1:0]  out_status;

  indexed_doubly_linked_list u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_entry_next   (out_entry_next),
    .out_entry_prev   (out_entry_prev),
    .out_new_entry    (out_new_entry),
    .out_head_index   (out_head_index),
    .out_tail_index   (out_tail_index),
    .out_count        (out_count),
    .out_status       (out_status)
  );

  // shadow of the pool
  logic [IDX_W-1:0] link_next [SLOTS];
  logic [IDX_W-1:0] link_prev [SLOTS];
  logic             live      [SLOTS];
  logic [VAL_W-1:0] payload   [SLOTS];
  logic [IDX_W-1:0] head_q, tail_q, free_q, size_q;

  list_cmd_t  queued_ops [$];
  list_resp_t predicted_results [$];
  list_cmd_t  on_bus;
  int         accepted = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  logic       calm;

  assign calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);

  function automatic logic [IDX_W-1:0] claim_entry(input logic [VAL_W-1:0] v);
    logic [IDX_W-1:0] e;
    e = free_q;
    free_q = link_next[e];
    payload[e] = v;
    live[e] = 1'b1;
    size_q = size_q + 1'b1;
    return e;
  endfunction

  function automatic logic [IDX_W-1:0] append_entry(input logic [VAL_W-1:0] v);
    logic [IDX_W-1:0] e;
    e = claim_entry(v);
    link_next[e] = '0;
    link_prev[e] = tail_q;
    if (tail_q == '0) head_q = e;
    else link_next[tail_q] = e;
    tail_q = e;
    return e;
  endfunction

  // unlink, return to the free chain, hand back the stored word
  function automatic logic [VAL_W-1:0] detach_entry(input logic [IDX_W-1:0] e);
    logic [IDX_W-1:0] n, p;
    n = link_next[e];
    p = link_prev[e];
    if (p == '0) head_q = n;
    else link_next[p] = n;
    if (n == '0) tail_q = p;
    else link_prev[n] = p;
    link_next[e] = free_q;
    link_prev[e] = '0;
    live[e] = 1'b0;
    free_q = e;
    size_q = size_q - 1'b1;
    return payload[e];
  endfunction

  function automatic list_resp_t apply_list_op(input list_cmd_t c);
    list_resp_t r;
    logic       pos_ok;
    logic [IDX_W-1:0] after;
    r = '{value: '0, nxt: '0, prv: '0, new_entry: '0, head: '0, tail: '0,
          count: '0, status: ST_OK};
    pos_ok = (c.pos != '0) && live[c.pos];
    case (c.op)
      OP_PUSH_BACK: begin
        if (free_q == '0) r.status = ST_FULL;
        else r.new_entry = append_entry(c.val);
      end
      OP_PUSH_FRONT: begin
        if (free_q == '0) begin
          r.status = ST_FULL;
        end else begin
          r.new_entry = claim_entry(c.val);
          link_prev[r.new_entry] = '0;
          link_next[r.new_entry] = head_q;
          if (head_q == '0) tail_q = r.new_entry;
          else link_prev[head_q] = r.new_entry;
          head_q = r.new_entry;
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (size_q == '0 || head_q == '0) r.status = ST_EMPTY;
        else r.value = detach_entry(c.op == OP_POP_BACK ? tail_q : head_q);
      end
      OP_INSERT_AFTER: begin
        // position check wins over the full-pool check
        if (!pos_ok) begin
          r.status = ST_BADPOS;
        end else if (free_q == '0) begin
          r.status = ST_FULL;
        end else if (c.pos == tail_q) begin
          r.new_entry = append_entry(c.val);
        end else begin
          after = link_next[c.pos];
          r.new_entry = claim_entry(c.val);
          link_next[r.new_entry] = after;
          link_prev[r.new_entry] = c.pos;
          link_prev[after] = r.new_entry;
          link_next[c.pos] = r.new_entry;
        end
      end
      OP_ERASE: begin
        if (!pos_ok) r.status = ST_BADPOS;
        else r.value = detach_entry(c.pos);
      end
      OP_READ: begin
        if (!pos_ok) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = payload[c.pos];
          r.nxt = link_next[c.pos];
          r.prv = link_prev[c.pos];
        end
      end
      default: ;
    endcase
    r.head = head_q;
    r.tail = tail_q;
    r.count = size_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(apply_list_op(on_bus));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_ops.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus = queued_ops.pop_front();
          in_valid <= 1'b1;
          in_operation <= on_bus.op;
          in_position <= on_bus.pos;
          in_value <= on_bus.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_resp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $display("%0t: transfer expected none, got value %0h status %0d",
                   $time, out_result_value, out_status);
        end else begin
          want = predicted_results.pop_front();
          check_field("result_value", want.value, out_result_value);
          check_field("entry_next", VAL_W'(want.nxt), VAL_W'(out_entry_next));
          check_field("entry_prev", VAL_W'(want.prv), VAL_W'(out_entry_prev));
          check_field("new_entry", VAL_W'(want.new_entry), VAL_W'(out_new_entry));
          check_field("head_index", VAL_W'(want.head), VAL_W'(out_head_index));
          check_field("tail_index", VAL_W'(want.tail), VAL_W'(out_tail_index));
          check_field("count", VAL_W'(want.count), VAL_W'(out_count));
          check_field("status", VAL_W'(want.status), VAL_W'(out_status));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    list_cmd_t        cmd;
    logic [IDX_W-1:0] picks [$];
    int               r;
    int               k;
    bit               grow;

    for (int i = 0; i < SLOTS; i++) begin
      link_next[i] = (i + 1 < SLOTS) ? IDX_W'(i + 1) : '0;
      link_prev[i] = '0;
      live[i] = 1'b0;
      payload[i] = '0;
    end
    link_next[0] = '0;
    head_q = '0;
    tail_q = '0;
    free_q = IDX_W'(1);
    size_q = '0;

    // empty pops, bad positions, then a small list built and torn down
    queued_ops.push_back('{OP_POP_BACK, 6'd0, 32'h0});
    queued_ops.push_back('{OP_POP_FRONT, 6'd63, 32'hFFFFFFFF});
    queued_ops.push_back('{OP_READ, 6'd0, 32'h0});
    queued_ops.push_back('{OP_ERASE, 6'd63, 32'h0});
    queued_ops.push_back('{OP_INSERT_AFTER, 6'd0, 32'h11111111});
    queued_ops.push_back('{OP_UNUSED, 6'd63, 32'hFFFFFFFF});
    queued_ops.push_back('{OP_PUSH_BACK, 6'd0, 32'h0});
    queued_ops.push_back('{OP_PUSH_BACK, 6'd0, 32'hFFFFFFFF});
    queued_ops.push_back('{OP_PUSH_FRONT, 6'd0, 32'hA5A5A5A5});
    queued_ops.push_back('{OP_INSERT_AFTER, 6'd1, 32'h5A5A5A5A});
    queued_ops.push_back('{OP_INSERT_AFTER, 6'd2, 32'h12345678});
    queued_ops.push_back('{OP_READ, 6'd4, 32'h0});
    queued_ops.push_back('{OP_READ, 6'd3, 32'h0});
    queued_ops.push_back('{OP_READ, 6'd5, 32'h0});
    queued_ops.push_back('{OP_ERASE, 6'd4, 32'h0});
    queued_ops.push_back('{OP_ERASE, 6'd3, 32'h0});
    queued_ops.push_back('{OP_ERASE, 6'd5, 32'h0});
    queued_ops.push_back('{OP_READ, 6'd4, 32'h0});
    queued_ops.push_back('{OP_INSERT_AFTER, 6'd63, 32'h87654321});
    queued_ops.push_back('{OP_POP_FRONT, 6'd0, 32'h0});
    queued_ops.push_back('{OP_POP_BACK, 6'd0, 32'h0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // alternate growing and shrinking phases so both full and empty are hit
    for (int n = 0; n < RANDOM_OPS; n++) begin
      @(negedge clk);
      while (queued_ops.size() >= 2) @(negedge clk);
      grow = ((n / PHASE_LEN) % 2) == 0;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      cmd.val = (k == 0) ? '0 : (k == 1) ? '1 : VAL_W'($urandom());
      cmd.pos = IDX_W'($urandom_range(0, SLOTS - 1));
      if (r < (grow ? 35 : 6)) cmd.op = OP_PUSH_BACK;
      else if (r < (grow ? 55 : 10)) cmd.op = OP_PUSH_FRONT;
      else if (r < (grow ? 80 : 14)) cmd.op = OP_INSERT_AFTER;
      else if (r < (grow ? 88 : 24)) cmd.op = OP_READ;
      else if (r < (grow ? 92 : 50)) cmd.op = OP_ERASE;
      else if (r < (grow ? 94 : 72)) cmd.op = OP_POP_BACK;
      else if (r < (grow ? 96 : 94)) cmd.op = OP_POP_FRONT;
      else if (r < (grow ? 97 : 96)) cmd.op = OP_UNUSED;
      else cmd.op = OP_W'($urandom_range(0, 7));
      // aim most positional ops at a listed entry
      if (r < 97 && (cmd.op == OP_INSERT_AFTER || cmd.op == OP_READ || cmd.op == OP_ERASE)) begin
        picks.delete();
        for (int i = 1; i < SLOTS; i++)
          if (live[i]) picks.push_back(IDX_W'(i));
        if (picks.size() > 0 && $urandom_range(0, 99) < 85)
          cmd.pos = picks[$urandom_range(0, picks.size() - 1)];
      end
      queued_ops.push_back(cmd);
    end

    while (queued_ops.size() > 0 || in_valid || predicted_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
